// ===== hdl/aqf_pkg.sv =====
// Shared widths, constants and helpers for the attitude quaternion fusion unit.
package aqf_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int OP_W       = 36;
  localparam int PROD_W     = 2 * OP_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int SH_W       = 6;

  localparam logic signed [ACC_W-1:0] WORD_MAX  = (ACC_W'(1) <<< (WORD_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] WORD_MIN  = -WORD_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] QTR_Q30   = ACC_W'(1) <<< 29;
  localparam logic signed [ACC_W-1:0] THREE_Q30 = ACC_W'(3) <<< 30;
  localparam logic signed [ACC_W-1:0] Y_CLAMP   = ACC_W'(1) <<< 31;

  localparam logic signed [WORD_WIDTH-1:0] ONE_Q30 = WORD_WIDTH'(1) <<< 30;
  localparam logic [31:0] ROOT_SEED = 32'd19 << 26;

  function automatic logic signed [WORD_WIDTH-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_WIDTH-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_MAX[WORD_WIDTH-1:0];
    end else if (v < WORD_MIN) begin
      r = WORD_MIN[WORD_WIDTH-1:0];
    end else begin
      r = v[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/aqf_mul_unit.sv =====
// Shared signed multiply with registered product and right shift, rounded when rnd is set.
module aqf_mul_unit import aqf_pkg::*; (
  input  logic                    clk,
  input  logic signed [OP_W-1:0]  op_a,
  input  logic signed [OP_W-1:0]  op_b,
  input  logic [SH_W-1:0]         shift,
  input  logic                    rnd,
  output logic signed [ACC_W-1:0] term
);

  logic [OP_W-1:0]   mag_a;
  logic [OP_W-1:0]   mag_b;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [SH_W-1:0]   shift_r;
  logic              rnd_r;
  logic [PROD_W:0]   rnd_add;
  logic [PROD_W:0]   sum;
  logic [PROD_W:0]   mag;

  assign mag_a = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
  assign mag_b = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);

  always_ff @(posedge clk) begin
    prod    <= mag_a * mag_b;
    neg     <= op_a[OP_W-1] ^ op_b[OP_W-1];
    shift_r <= shift;
    rnd_r   <= rnd;
  end

  always_comb begin
    rnd_add = '0;
    if (rnd_r && (shift_r != '0)) begin
      rnd_add = (PROD_W + 1)'(1) << (shift_r - SH_W'(1));
    end
    sum  = {1'b0, prod} + rnd_add;
    mag  = sum >> shift_r;
    term = neg ? -ACC_W'(mag) : ACC_W'(mag);
  end

endmodule

// ===== hdl/attitude_quaternion_fusion_unit.sv =====
// Top level: sequencer and state of the attitude quaternion fusion unit.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | func, rate_x/y/z, accel_x/y/z, time_step
//  out     | out_valid / out_stall  | quat_w/x/y/z, accel_used
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//
// One item at a time; every multiply goes through the single shared multiplier.
// An update takes longer with accelerometer correction than without it.
// Synchronous reset restores the identity attitude, clears the bias and loads gains.
// A result waits in the output register while the next beat is taken.
module attitude_quaternion_fusion_unit import aqf_pkg::*; #(
  parameter int ROOT_ITERATIONS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic [31:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               accel_used,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IT_W = $clog2(ROOT_ITERATIONS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ASQ    = 4'd1;
  localparam logic [3:0] ST_RNORM  = 4'd2;
  localparam logic [3:0] ST_RSEED  = 4'd3;
  localparam logic [3:0] ST_RIT    = 4'd4;
  localparam logic [3:0] ST_RSCALE = 4'd5;
  localparam logic [3:0] ST_GRAV   = 4'd6;
  localparam logic [3:0] ST_ERR    = 4'd7;
  localparam logic [3:0] ST_FB     = 4'd8;
  localparam logic [3:0] ST_HALF   = 4'd9;
  localparam logic [3:0] ST_PRED   = 4'd10;
  localparam logic [3:0] ST_SHIFT  = 4'd11;
  localparam logic [3:0] ST_PS     = 4'd12;
  localparam logic [3:0] ST_QSQ    = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  localparam logic CFG_PROP  = 1'b0;
  localparam logic CFG_INTEG = 1'b1;

  logic [3:0]      state;
  logic            ph;
  logic [1:0]      grp;
  logic [1:0]      idx;
  logic [IT_W-1:0] it;

  logic [31:0] pg;
  logic [31:0] ig;

  logic signed [31:0] q   [4];
  logic signed [31:0] bi  [3];
  logic signed [37:0] g   [3];
  logic signed [31:0] av  [3];
  logic signed [31:0] an  [3];
  logic signed [31:0] hv  [3];
  logic signed [31:0] e   [3];
  logic signed [31:0] h   [3];
  logic signed [35:0] p   [4];
  logic signed [31:0] ps  [4];
  logic [31:0]        dt;
  logic signed [32:0] edt;
  logic [35:0]        mx;
  logic [SH_W-1:0]    psh;
  logic [63:0]        rv;
  logic [6:0]         hk;
  logic [31:0]        y;
  logic [32:0]        tmp;
  logic [31:0]        f;
  logic               rsel;
  logic               used;
  logic signed [ACC_W-1:0] acc;

  logic signed [OP_W-1:0]  opa;
  logic signed [OP_W-1:0]  opb;
  logic [SH_W-1:0]         osh;
  logic                    ornd;
  logic                    first;
  logic                    sub;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_src;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [ACC_W-1:0] fdiff;
  logic [35:0]             pmag;
  logic [33:0]             v3;
  logic                    is_op;
  logic signed [WORD_WIDTH-1:0] acc_sat;

  aqf_mul_unit u_mul (
    .clk   (clk),
    .op_a  (opa),
    .op_b  (opb),
    .shift (osh),
    .rnd   (ornd),
    .term  (term)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    opa   = '0;
    opb   = '0;
    osh   = '0;
    ornd  = 1'b1;
    first = 1'b1;
    sub   = 1'b0;
    base  = '0;
    case (state)
      ST_ASQ: begin
        opa   = OP_W'(av[grp]);
        opb   = OP_W'(av[grp]);
        first = (grp == 2'd0);
      end
      ST_RIT: begin
        ornd = 1'b0;
        case (idx)
          2'd0: begin
            opa = OP_W'(y);
            opb = OP_W'(y);
            osh = SH_W'(30);
          end
          2'd1: begin
            opa = OP_W'(tmp);
            opb = OP_W'(rv[31:0]);
            osh = SH_W'(30);
          end
          default: begin
            opa = OP_W'(y);
            opb = OP_W'(f);
            osh = SH_W'(31);
          end
        endcase
      end
      ST_RSCALE: begin
        opa = rsel ? OP_W'(ps[grp]) : OP_W'(av[grp]);
        opb = OP_W'(y);
        osh = hk[6:1];
      end
      ST_GRAV: begin
        osh   = SH_W'(30);
        first = (idx == 2'd0);
        case (grp)
          2'd0: begin
            opa = idx[0] ? OP_W'(q[0]) : OP_W'(q[1]);
            opb = idx[0] ? OP_W'(q[2]) : OP_W'(q[3]);
            sub = idx[0];
          end
          2'd1: begin
            opa = idx[0] ? OP_W'(q[2]) : OP_W'(q[0]);
            opb = idx[0] ? OP_W'(q[3]) : OP_W'(q[1]);
          end
          default: begin
            opa  = idx[0] ? OP_W'(q[3]) : OP_W'(q[0]);
            opb  = opa;
            base = -QTR_Q30;
          end
        endcase
      end
      ST_ERR: begin
        osh   = SH_W'(30);
        first = (idx == 2'd0);
        sub   = idx[0];
        case (grp)
          2'd0: begin
            opa = idx[0] ? OP_W'(an[2]) : OP_W'(an[1]);
            opb = idx[0] ? OP_W'(hv[1]) : OP_W'(hv[2]);
          end
          2'd1: begin
            opa = idx[0] ? OP_W'(an[0]) : OP_W'(an[2]);
            opb = idx[0] ? OP_W'(hv[2]) : OP_W'(hv[0]);
          end
          default: begin
            opa = idx[0] ? OP_W'(an[1]) : OP_W'(an[0]);
            opb = idx[0] ? OP_W'(hv[0]) : OP_W'(hv[1]);
          end
        endcase
      end
      ST_FB: begin
        case (idx)
          2'd0: begin
            opa = OP_W'(e[grp]);
            opb = OP_W'(dt);
            osh = SH_W'(32);
          end
          2'd1: begin
            opa  = OP_W'(edt);
            opb  = OP_W'(ig);
            osh  = SH_W'(28);
            base = ACC_W'(bi[grp]);
          end
          default: begin
            opa  = OP_W'(e[grp]);
            opb  = OP_W'(pg);
            osh  = SH_W'(28);
            base = ACC_W'(g[grp]) + ((ig != '0) ? ACC_W'(bi[grp]) : ACC_W'(0));
          end
        endcase
      end
      ST_HALF: begin
        opa = OP_W'(sat_word(ACC_W'(g[grp])));
        opb = OP_W'(dt);
        osh = SH_W'(29);
      end
      ST_PRED: begin
        osh   = SH_W'(30);
        first = (idx == 2'd0);
        base  = ACC_W'(q[grp]);
        case ({grp, idx})
          4'b00_00: begin opa = OP_W'(q[1]); opb = OP_W'(h[0]); sub = 1'b1; end
          4'b00_01: begin opa = OP_W'(q[2]); opb = OP_W'(h[1]); sub = 1'b1; end
          4'b00_10: begin opa = OP_W'(q[3]); opb = OP_W'(h[2]); sub = 1'b1; end
          4'b01_00: begin opa = OP_W'(q[0]); opb = OP_W'(h[0]); end
          4'b01_01: begin opa = OP_W'(q[2]); opb = OP_W'(h[2]); end
          4'b01_10: begin opa = OP_W'(q[3]); opb = OP_W'(h[1]); sub = 1'b1; end
          4'b10_00: begin opa = OP_W'(q[0]); opb = OP_W'(h[1]); end
          4'b10_01: begin opa = OP_W'(q[1]); opb = OP_W'(h[2]); sub = 1'b1; end
          4'b10_10: begin opa = OP_W'(q[3]); opb = OP_W'(h[0]); end
          4'b11_00: begin opa = OP_W'(q[0]); opb = OP_W'(h[2]); end
          4'b11_01: begin opa = OP_W'(q[1]); opb = OP_W'(h[1]); end
          4'b11_10: begin opa = OP_W'(q[2]); opb = OP_W'(h[0]); sub = 1'b1; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      ST_PS: begin
        opa = OP_W'(p[grp]);
        opb = OP_W'(1);
        osh = psh;
      end
      ST_QSQ: begin
        opa   = OP_W'(ps[grp]);
        opb   = OP_W'(ps[grp]);
        first = (grp == 2'd0);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    is_op   = state inside {ST_ASQ, ST_RIT, ST_RSCALE, ST_GRAV, ST_ERR, ST_FB,
                            ST_HALF, ST_PRED, ST_PS, ST_QSQ};
    acc_src = first ? base : acc;
    acc_new = acc_src + (sub ? -term : term);
    acc_sat = sat_word(acc_new);
    fdiff   = THREE_Q30 - acc_new;
    pmag    = acc_new[ACC_W-1] ? 36'(-acc_new) : 36'(acc_new);
    v3      = {2'b00, rv[31:0]} + {1'b0, rv[31:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= 1'b0;
      grp       <= '0;
      idx       <= '0;
      it        <= '0;
      out_valid <= 1'b0;
      pg        <= 32'd8388608;
      ig        <= 32'd1677722;
      q[0]      <= ONE_Q30;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
      bi[0]     <= '0;
      bi[1]     <= '0;
      bi[2]     <= '0;
      used      <= 1'b0;
      rsel      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PROP:  pg <= cfg_data;
          CFG_INTEG: ig <= cfg_data;
          default:   pg <= pg;
        endcase
      end
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      if (is_op && !ph) begin
        ph <= 1'b1;
      end else begin
        ph <= 1'b0;
        if (is_op) begin
          acc <= acc_new;
        end
        case (state)
          ST_IDLE: begin
            if (in_valid) begin
              if (func) begin
                q[0]  <= ONE_Q30;
                q[1]  <= '0;
                q[2]  <= '0;
                q[3]  <= '0;
                bi[0] <= '0;
                bi[1] <= '0;
                bi[2] <= '0;
                used  <= 1'b0;
                state <= ST_OUT;
              end else begin
                g[0]  <= 38'(rate_x);
                g[1]  <= 38'(rate_y);
                g[2]  <= 38'(rate_z);
                av[0] <= accel_x;
                av[1] <= accel_y;
                av[2] <= accel_z;
                dt    <= time_step;
                grp   <= '0;
                idx   <= '0;
                state <= ST_ASQ;
              end
            end
          end
          ST_ASQ: begin
            if (grp == 2'd2) begin
              grp <= '0;
              if (acc_new[63:0] > (64'd1 << 54) && acc_new[63:0] < (64'd1 << 58)) begin
                rv    <= acc_new[63:0];
                hk    <= 7'd30;
                rsel  <= 1'b0;
                used  <= 1'b1;
                state <= ST_RNORM;
              end else begin
                used  <= 1'b0;
                state <= ST_HALF;
              end
            end else begin
              grp <= grp + 2'd1;
            end
          end
          ST_RNORM: begin
            if (rv >= (64'd1 << 32)) begin
              rv <= rv >> 2;
              hk <= hk + 7'd2;
            end else if (rv < (64'd1 << 30)) begin
              rv <= rv << 2;
              hk <= hk - 7'd2;
            end else begin
              state <= ST_RSEED;
            end
          end
          ST_RSEED: begin
            y     <= ROOT_SEED - 32'(v3 >> 4);
            it    <= '0;
            idx   <= '0;
            state <= ST_RIT;
          end
          ST_RIT: begin
            case (idx)
              2'd0: begin
                tmp <= acc_new[32:0];
                idx <= 2'd1;
              end
              2'd1: begin
                f   <= fdiff[ACC_W-1] ? 32'd0 : fdiff[31:0];
                idx <= 2'd2;
              end
              default: begin
                y   <= (acc_new > Y_CLAMP) ? 32'h8000_0000 : acc_new[31:0];
                idx <= 2'd0;
                if (it == IT_W'(ROOT_ITERATIONS - 1)) begin
                  grp   <= '0;
                  state <= ST_RSCALE;
                end else begin
                  it <= it + IT_W'(1);
                end
              end
            endcase
          end
          ST_RSCALE: begin
            if (rsel) begin
              q[grp] <= acc_sat;
              if (grp == 2'd3) begin
                grp   <= '0;
                state <= ST_OUT;
              end else begin
                grp <= grp + 2'd1;
              end
            end else begin
              an[grp] <= acc_sat;
              if (grp == 2'd2) begin
                grp   <= '0;
                idx   <= '0;
                state <= ST_GRAV;
              end else begin
                grp <= grp + 2'd1;
              end
            end
          end
          ST_GRAV, ST_ERR: begin
            if (idx == 2'd1) begin
              if (state == ST_GRAV) begin
                hv[grp] <= acc_sat;
              end else begin
                e[grp] <= acc_sat;
              end
              if (grp == 2'd2) begin
                grp <= '0;
                if (state == ST_GRAV) begin
                  idx   <= '0;
                  state <= ST_ERR;
                end else begin
                  idx   <= (ig != '0) ? 2'd0 : 2'd2;
                  state <= ST_FB;
                end
              end else begin
                idx <= '0;
                grp <= grp + 2'd1;
              end
            end else begin
              idx <= 2'd1;
            end
          end
          ST_FB: begin
            case (idx)
              2'd0: begin
                edt <= acc_new[32:0];
                idx <= 2'd1;
              end
              2'd1: begin
                bi[grp] <= acc_sat;
                idx     <= 2'd2;
              end
              default: begin
                g[grp] <= acc_new[37:0];
                idx    <= (ig != '0) ? 2'd0 : 2'd2;
                if (grp == 2'd2) begin
                  grp   <= '0;
                  state <= ST_HALF;
                end else begin
                  grp <= grp + 2'd1;
                end
              end
            endcase
          end
          ST_HALF: begin
            h[grp] <= acc_sat;
            if (grp == 2'd2) begin
              grp   <= '0;
              idx   <= '0;
              mx    <= '0;
              state <= ST_PRED;
            end else begin
              grp <= grp + 2'd1;
            end
          end
          ST_PRED: begin
            if (idx == 2'd2) begin
              p[grp] <= acc_new[35:0];
              mx     <= (pmag > mx) ? pmag : mx;
              idx    <= '0;
              if (grp == 2'd3) begin
                grp   <= '0;
                psh   <= '0;
                state <= ST_SHIFT;
              end else begin
                grp <= grp + 2'd1;
              end
            end else begin
              idx <= idx + 2'd1;
            end
          end
          ST_SHIFT: begin
            if (mx >= (36'd1 << 30)) begin
              mx  <= mx >> 1;
              psh <= psh + SH_W'(1);
            end else begin
              grp   <= '0;
              state <= ST_PS;
            end
          end
          ST_PS: begin
            ps[grp] <= acc_new[31:0];
            if (grp == 2'd3) begin
              grp   <= '0;
              state <= ST_QSQ;
            end else begin
              grp <= grp + 2'd1;
            end
          end
          ST_QSQ: begin
            if (grp == 2'd3) begin
              grp <= '0;
              if (acc_new == '0) begin
                q[0]  <= ONE_Q30;
                q[1]  <= '0;
                q[2]  <= '0;
                q[3]  <= '0;
                state <= ST_OUT;
              end else begin
                rv    <= acc_new[63:0];
                hk    <= 7'd30;
                rsel  <= 1'b1;
                state <= ST_RNORM;
              end
            end else begin
              grp <= grp + 2'd1;
            end
          end
          ST_OUT: begin
            if (!out_valid || !out_stall) begin
              quat_w     <= q[0];
              quat_x     <= q[1];
              quat_y     <= q[2];
              quat_z     <= q[3];
              accel_used <= used;
              out_valid  <= 1'b1;
              state      <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule
